@@ hdl/mcaq_pkg.sv @@
// Package for the multi-consumer acknowledgement queue.
// Holds request codes, register indexes, port widths and parameter defaults.
// No dependencies.
package mcaq_pkg;

    // Parameter defaults.
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int MAX_CONSUMERS_DEF = 16;

    // Port widths fixed by the interface.
    localparam int CID_W   = 32;
    localparam int BID_W   = 64;
    localparam int SEQ_W   = 32;
    localparam int SIZE_W  = 32;
    localparam int QCNT_W  = 4;
    localparam int RCNT_W  = 5;
    localparam int CFG_W   = 32;
    localparam int LIMIT_W = 4;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 4'd8;
    localparam logic [CFG_W-1:0]   CAPACITY_RST = 32'd65536;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_PUBLISH    = 2'd2,
        REQ_ACK        = 2'd3
    } t_req;

    // Configuration register indexes.
    typedef enum logic {
        CFG_QUEUE_LIMIT   = 1'b0,
        CFG_DATA_CAPACITY = 1'b1
    } t_cfg_idx;

endpackage

@@ hdl/mcaq_eq.sv @@
// Shared equality unit of the acknowledgement queue sequencer.
// Depends on mcaq_pkg for the default operand width.
module mcaq_eq import mcaq_pkg::*; #(
    parameter int WIDTH = BID_W
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_eq
);

    // One wide compare, reused by every search of the sequencer.
    assign o_eq = ~|(i_a ^ i_b);

endmodule

@@ hdl/multi_consumer_ack_queue.sv @@
// Multi-consumer acknowledgement queue: one request beat in, one result beat out.
// A request is taken when i_start is high and o_busy is low. Its result beat shows on o_valid for
// one cycle, and the receiver cannot stall it, so results never back up. A publish without
// acknowledgement, and a publish that fails the size check, finish in the accepting cycle and
// keep o_busy low. Register and unregister hold o_busy while the search and, on unregister, the
// shift down walk the list: together they visit each list entry once. Publish with acknowledgement
// holds it through one purge pass, the opening of the entry and one copy step per consumer.
// Acknowledge reads and then compares each queued entry searched and each consumer slot checked,
// as set by the registered reads of the entry memories and the single shared comparator.
// Depends on mcaq_pkg and mcaq_eq.
module multi_consumer_ack_queue import mcaq_pkg::*; #(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_req_type,
    input  logic [CID_W-1:0]  i_consumer_id,
    input  logic [BID_W-1:0]  i_ack_buffer_id,
    input  logic              i_needs_ack,
    input  logic [SIZE_W-1:0] i_data_size,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_valid,
    output logic              o_ok,
    output logic [BID_W-1:0]  o_new_buffer_id,
    output logic [SEQ_W-1:0]  o_new_sequence,
    output logic [QCNT_W-1:0] o_queue_count,
    output logic [RCNT_W-1:0] o_registered_count,
    output logic [QCNT_W-1:0] o_fully_acked_count
);

    localparam int QIW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW    = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
    localparam int CCW    = $clog2(MAX_CONSUMERS + 1);
    localparam int CMW    = QIW + CIW;
    localparam int META_W = MAX_CONSUMERS + 2 * CCW;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CSRCH  = 10'b00_0000_0010,
        S_CSHIFT = 10'b00_0000_0100,
        S_PURGE  = 10'b00_0000_1000,
        S_PUBWR  = 10'b00_0001_0000,
        S_COPY   = 10'b00_0010_0000,
        S_ARD    = 10'b00_0100_0000,
        S_ACMP   = 10'b00_1000_0000,
        S_KRD    = 10'b01_0000_0000,
        S_KCMP   = 10'b10_0000_0000
    } t_state;

    // Control and request registers.
    t_state                  r_state, n_state;
    t_req                    r_req, n_req;
    logic [CID_W-1:0]        r_cid, n_cid;
    logic [BID_W-1:0]        r_abid, n_abid;
    logic [LIMIT_W-1:0]      r_qlim;
    logic [CFG_W-1:0]        r_cap;
    logic [BID_W-1:0]        r_next_id, n_next_id;
    logic [SEQ_W-1:0]        r_next_seq, n_next_seq;
    logic [BID_W-1:0]        r_pid, n_pid;
    logic [SEQ_W-1:0]        r_pseq, n_pseq;
    logic [CCW-1:0]          r_ct, n_ct;
    logic [QCW-1:0]          r_qt, n_qt;
    logic [QCW-1:0]          r_ndone, n_ndone;
    logic [CCW-1:0]          r_ci, n_ci;
    logic [QCW-1:0]          r_qi, n_qi;
    logic [QCW-1:0]          r_w, n_w;
    logic [QIW-1:0]          r_slot, n_slot;
    logic [CID_W-1:0]        r_list [MAX_CONSUMERS];
    logic [CID_W-1:0]        n_list [MAX_CONSUMERS];
    logic [QIW-1:0]          r_order [QUEUE_DEPTH];
    logic [QIW-1:0]          n_order [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  r_done, n_done;

    // Result registers.
    logic                    r_valid, n_valid;
    logic                    r_ok, n_ok;
    logic [BID_W-1:0]        r_onid, n_onid;
    logic [SEQ_W-1:0]        r_oseq, n_oseq;

    // Entry memories with registered read data.
    logic [BID_W-1:0]        m_ids  [QUEUE_DEPTH];
    logic [META_W-1:0]       m_meta [QUEUE_DEPTH];
    logic [CID_W-1:0]        m_cons [QUEUE_DEPTH << CIW];
    logic [BID_W-1:0]        r_id_q;
    logic [META_W-1:0]       r_meta_q;
    logic [CID_W-1:0]        r_cons_q;
    logic                    ids_we, meta_we, cons_we;
    logic [QIW-1:0]          ids_ra, meta_wa;
    logic [META_W-1:0]       meta_wd;
    logic [CMW-1:0]          cons_wa, cons_ra;
    logic [CID_W-1:0]        cons_wd;

    // Shared comparator operands.
    logic [BID_W-1:0]        cmp_a, cmp_b;
    logic                    cmp_eq;

    // Fields of the entry metadata word read back.
    logic [MAX_CONSUMERS-1:0] meta_flags;
    logic [CCW-1:0]           meta_ctot;
    logic [CCW-1:0]           meta_atot;
    logic                     q_room;

    assign meta_flags = r_meta_q[META_W-1 -: MAX_CONSUMERS];
    assign meta_ctot  = r_meta_q[2*CCW-1 -: CCW];
    assign meta_atot  = r_meta_q[CCW-1:0];
    assign q_room     = (32'(r_qt) < 32'(r_qlim)) && (32'(r_qt) < QUEUE_DEPTH);

    mcaq_eq #(.WIDTH(BID_W)) u_eq (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_eq (cmp_eq)
    );

    // Operand select for the shared comparator.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (r_state)
            S_CSRCH: begin
                cmp_a = BID_W'(r_list[r_ci[CIW-1:0]]);
                cmp_b = BID_W'(r_cid);
            end
            S_ACMP: begin
                cmp_a = r_id_q;
                cmp_b = r_abid;
            end
            S_KCMP: begin
                cmp_a = BID_W'(r_cons_q);
                cmp_b = BID_W'(r_cid);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cid      = r_cid;
        n_abid     = r_abid;
        n_next_id  = r_next_id;
        n_next_seq = r_next_seq;
        n_pid      = r_pid;
        n_pseq     = r_pseq;
        n_ct       = r_ct;
        n_qt       = r_qt;
        n_ndone    = r_ndone;
        n_ci       = r_ci;
        n_qi       = r_qi;
        n_w        = r_w;
        n_slot     = r_slot;
        n_list     = r_list;
        n_order    = r_order;
        n_done     = r_done;
        n_valid    = 1'b0;
        n_ok       = r_ok;
        n_onid     = r_onid;
        n_oseq     = r_oseq;
        ids_we     = 1'b0;
        ids_ra     = r_slot;
        meta_we    = 1'b0;
        meta_wa    = r_slot;
        meta_wd    = '0;
        cons_we    = 1'b0;
        cons_wa    = {r_slot, r_ci[CIW-1:0]};
        cons_wd    = r_list[r_ci[CIW-1:0]];
        cons_ra    = {r_slot, r_ci[CIW-1:0]};

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req  = t_req'(i_req_type);
                    n_cid  = i_consumer_id;
                    n_abid = i_ack_buffer_id;
                    n_ci   = '0;
                    n_qi   = '0;
                    n_w    = '0;
                    n_onid = '0;
                    n_oseq = '0;
                    unique case (t_req'(i_req_type))
                        REQ_REGISTER, REQ_UNREGISTER: begin
                            n_state = S_CSRCH;
                        end
                        REQ_PUBLISH: begin
                            if (i_data_size <= r_cap) begin
                                n_pid      = r_next_id;
                                n_pseq     = r_next_seq;
                                n_next_id  = r_next_id + 1'b1;
                                n_next_seq = r_next_seq + 1'b1;
                                if (i_needs_ack) begin
                                    n_state = S_PURGE;
                                end else begin
                                    n_valid = 1'b1;
                                    n_ok    = 1'b1;
                                    n_onid  = r_next_id;
                                    n_oseq  = r_next_seq;
                                end
                            end else begin
                                n_valid = 1'b1;
                                n_ok    = 1'b0;
                            end
                        end
                        REQ_ACK: begin
                            n_state = S_ARD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk the consumer list looking for the request's ID.
            S_CSRCH: begin
                if (r_ci == r_ct) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    if (r_req == REQ_REGISTER && 32'(r_ct) < MAX_CONSUMERS) begin
                        n_list[r_ct[CIW-1:0]] = r_cid;
                        n_ct = r_ct + 1'b1;
                        n_ok = 1'b1;
                    end
                end else if (cmp_eq) begin
                    if (r_req == REQ_REGISTER) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_ok    = 1'b1;
                    end else begin
                        n_state = S_CSHIFT;
                    end
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end

            // Close the gap left by an unregistered consumer.
            S_CSHIFT: begin
                if (r_ci + 1'b1 < r_ct) begin
                    n_list[r_ci[CIW-1:0]] = r_list[CIW'(r_ci + 1'b1)];
                    n_ci = r_ci + 1'b1;
                end else begin
                    n_ct    = r_ct - 1'b1;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                end
            end

            // Stable compaction of the order list: kept slots move to the front.
            S_PURGE: begin
                if (r_qi == r_qt) begin
                    n_qt    = r_w;
                    n_ndone = '0;
                    n_state = S_PUBWR;
                end else begin
                    if (!r_done[r_order[r_qi[QIW-1:0]]]) begin
                        n_order[r_w[QIW-1:0]]  = r_order[r_qi[QIW-1:0]];
                        n_order[r_qi[QIW-1:0]] = r_order[r_w[QIW-1:0]];
                        n_w = r_w + 1'b1;
                    end
                    n_qi = r_qi + 1'b1;
                end
            end

            // Open a new entry in the first free slot.
            S_PUBWR: begin
                if (q_room) begin
                    n_slot  = r_order[r_qt[QIW-1:0]];
                    ids_we  = 1'b1;
                    meta_we = 1'b1;
                    meta_wa = r_order[r_qt[QIW-1:0]];
                    meta_wd = {{MAX_CONSUMERS{1'b0}}, r_ct, {CCW{1'b0}}};
                    n_done[r_order[r_qt[QIW-1:0]]] = (r_ct == '0);
                    n_ndone = r_ndone + QCW'(r_ct == '0);
                    n_ci    = '0;
                    n_state = S_COPY;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                end
            end

            // Snapshot the consumer list into the entry, one consumer a beat.
            S_COPY: begin
                if (r_ci == r_ct) begin
                    n_qt    = r_qt + 1'b1;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_onid  = r_pid;
                    n_oseq  = r_pseq;
                end else begin
                    cons_we = 1'b1;
                    n_ci    = r_ci + 1'b1;
                end
            end

            // Search the queue in order for the acknowledged buffer ID.
            S_ARD: begin
                if (r_qi == r_qt) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                end else begin
                    ids_ra  = r_order[r_qi[QIW-1:0]];
                    n_slot  = r_order[r_qi[QIW-1:0]];
                    n_state = S_ACMP;
                end
            end

            S_ACMP: begin
                if (cmp_eq) begin
                    n_ci    = '0;
                    n_state = S_KRD;
                end else begin
                    n_qi    = r_qi + 1'b1;
                    n_state = S_ARD;
                end
            end

            // Walk the entry's consumers for an unacknowledged match.
            S_KRD: begin
                if (r_ci == meta_ctot) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                end else begin
                    n_state = S_KCMP;
                end
            end

            S_KCMP: begin
                if (cmp_eq && !meta_flags[r_ci[CIW-1:0]]) begin
                    meta_we = 1'b1;
                    meta_wd = {meta_flags | (MAX_CONSUMERS'(1) << r_ci[CIW-1:0]),
                               meta_ctot, CCW'(meta_atot + 1'b1)};
                    if (CCW'(meta_atot + 1'b1) == meta_ctot) begin
                        n_done[r_slot] = 1'b1;
                        n_ndone = r_ndone + 1'b1;
                    end
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                end else begin
                    n_ci    = r_ci + 1'b1;
                    n_state = S_KRD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_qlim     <= LIMIT_RST;
            r_cap      <= CAPACITY_RST;
            r_next_id  <= BID_W'(1);
            r_next_seq <= '0;
            r_ct       <= '0;
            r_qt       <= '0;
            r_ndone    <= '0;
            r_valid    <= 1'b0;
            r_ok       <= 1'b0;
            r_onid     <= '0;
            r_oseq     <= '0;
            for (int q = 0; q < QUEUE_DEPTH; q++) begin
                r_order[q] <= QIW'(q);
            end
        end else begin
            r_state    <= n_state;
            r_next_id  <= n_next_id;
            r_next_seq <= n_next_seq;
            r_ct       <= n_ct;
            r_qt       <= n_qt;
            r_ndone    <= n_ndone;
            r_valid    <= n_valid;
            r_ok       <= n_ok;
            r_onid     <= n_onid;
            r_oseq     <= n_oseq;
            r_order    <= n_order;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_QUEUE_LIMIT:   r_qlim <= i_cfg_data[LIMIT_W-1:0];
                    CFG_DATA_CAPACITY: r_cap  <= i_cfg_data;
                    default:           r_qlim <= r_qlim;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cid  <= n_cid;
        r_abid <= n_abid;
        r_pid  <= n_pid;
        r_pseq <= n_pseq;
        r_ci   <= n_ci;
        r_qi   <= n_qi;
        r_w    <= n_w;
        r_slot <= n_slot;
        r_list <= n_list;
        r_done <= n_done;
    end

    // Entry ID memory.
    always_ff @(posedge i_clk) begin
        if (ids_we) begin
            m_ids[n_slot] <= r_pid;
        end
        r_id_q <= m_ids[ids_ra];
    end

    // Entry metadata memory: acknowledged flags, consumer total, ack total.
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            m_meta[meta_wa] <= meta_wd;
        end
        r_meta_q <= m_meta[r_slot];
    end

    // Consumer snapshot memory, one row of consumers per slot.
    always_ff @(posedge i_clk) begin
        if (cons_we) begin
            m_cons[cons_wa] <= cons_wd;
        end
        r_cons_q <= m_cons[cons_ra];
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_ok                = r_ok;
    assign o_new_buffer_id     = r_onid;
    assign o_new_sequence      = r_oseq;
    assign o_queue_count       = QCNT_W'(r_qt);
    assign o_registered_count  = RCNT_W'(r_ct);
    assign o_fully_acked_count = QCNT_W'(r_ndone);

endmodule

@@ test/mcaq_checker.sv @@
`timescale 1ns / 1ps
// Checker for the multi-consumer acknowledgement queue: watches request, config and result ports.
// Keeps its own copy of the consumer list and the ack queue and compares every result beat.
// Depends on mcaq_pkg.
module mcaq_checker import mcaq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_req_type,
    input  logic [CID_W-1:0]  i_consumer_id,
    input  logic [BID_W-1:0]  i_ack_buffer_id,
    input  logic              i_needs_ack,
    input  logic [SIZE_W-1:0] i_data_size,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    input  logic              i_ok,
    input  logic [BID_W-1:0]  i_new_buffer_id,
    input  logic [SEQ_W-1:0]  i_new_sequence,
    input  logic [QCNT_W-1:0] i_queue_count,
    input  logic [RCNT_W-1:0] i_registered_count,
    input  logic [QCNT_W-1:0] i_fully_acked_count,
    output int                o_errors,
    output int                o_pending
);

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int MC = MAX_CONSUMERS_DEF;

    typedef struct packed {
        logic              ok;
        logic [BID_W-1:0]  bid;
        logic [SEQ_W-1:0]  seq;
        logic [QCNT_W-1:0] qcount;
        logic [RCNT_W-1:0] rcount;
        logic [QCNT_W-1:0] acked;
    } t_result;

    // Shadow state of the block.
    logic [CID_W-1:0]   members[MC];
    int                 member_total;
    logic [BID_W-1:0]   slot_bid[QD];
    logic [CID_W-1:0]   slot_members[QD][MC];
    logic [MC-1:0]      slot_flags[QD];
    int                 slot_total[QD];
    int                 slot_acks[QD];
    int                 slot_count;
    logic [BID_W-1:0]   next_bid;
    logic [SEQ_W-1:0]   next_seq;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CFG_W-1:0]   capacity_reg;

    t_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic int find_member(logic [CID_W-1:0] cid);
        for (int i = 0; i < member_total; i++)
            if (members[i] == cid) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int idx);
        for (int j = idx; j + 1 < slot_count; j++) begin
            slot_bid[j]     = slot_bid[j+1];
            slot_flags[j]   = slot_flags[j+1];
            slot_total[j]   = slot_total[j+1];
            slot_acks[j]    = slot_acks[j+1];
            slot_members[j] = slot_members[j+1];
        end
        if (slot_count > 0) slot_count--;
    endfunction

    // Applies one request to the shadow state and returns the result it should produce.
    function automatic t_result apply_request(t_req req, logic [CID_W-1:0] cid,
                                              logic [BID_W-1:0] abid, logic need,
                                              logic [SIZE_W-1:0] dsize);
        t_result r;
        int      p;
        int      lim;
        int      i;
        int      done;
        logic [BID_W-1:0] bid;
        logic [SEQ_W-1:0] seq;
        r   = '0;
        lim = (limit_reg < QD) ? limit_reg : QD;
        case (req)
            REQ_REGISTER: begin
                if (find_member(cid) >= 0) begin
                    r.ok = 1'b1;
                end else if (member_total < MC) begin
                    members[member_total] = cid;
                    member_total++;
                    r.ok = 1'b1;
                end
            end
            REQ_UNREGISTER: begin
                p = find_member(cid);
                if (p >= 0) begin
                    for (i = p; i + 1 < member_total; i++) members[i] = members[i+1];
                    member_total--;
                    r.ok = 1'b1;
                end
            end
            REQ_PUBLISH: begin
                if (dsize <= capacity_reg) begin
                    bid = next_bid;
                    seq = next_seq;
                    next_bid++;
                    next_seq++;
                    if (!need) begin
                        r.ok = 1'b1;
                    end else begin
                        // Purge fully acknowledged entries, oldest first.
                        i = 0;
                        while (i < slot_count) begin
                            if (slot_acks[i] >= slot_total[i]) drop_slot(i);
                            else i++;
                        end
                        if (slot_count < lim) begin
                            slot_bid[slot_count]     = bid;
                            slot_total[slot_count]   = member_total;
                            slot_acks[slot_count]    = 0;
                            slot_flags[slot_count]   = '0;
                            slot_members[slot_count] = members;
                            slot_count++;
                            r.ok = 1'b1;
                        end
                    end
                    if (r.ok) begin
                        r.bid = bid;
                        r.seq = seq;
                    end
                end
            end
            default: begin
                // Only the first entry with a matching ID is considered.
                for (i = 0; i < slot_count; i++)
                    if (slot_bid[i] == abid) break;
                if (i < slot_count) begin
                    for (int k = 0; k < slot_total[i]; k++) begin
                        if (slot_members[i][k] == cid && !slot_flags[i][k]) begin
                            slot_flags[i][k] = 1'b1;
                            slot_acks[i]++;
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
        endcase
        done = 0;
        for (i = 0; i < slot_count; i++)
            if (slot_acks[i] == slot_total[i]) done++;
        r.qcount = slot_count[QCNT_W-1:0];
        r.rcount = member_total[RCNT_W-1:0];
        r.acked  = done[QCNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            member_total = 0;
            slot_count   = 0;
            next_bid     = 64'd1;
            next_seq     = '0;
            limit_reg    = LIMIT_RST;
            capacity_reg = CAPACITY_RST;
            o_errors     = 0;
            expected_results.delete();
        end else begin
            // Result beats are checked before a beat accepted at the same edge is predicted.
            if (i_valid) begin
                got = '{i_ok, i_new_buffer_id, i_new_sequence, i_queue_count,
                        i_registered_count, i_fully_acked_count};
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("ERROR: result beat with nothing expected: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("ERROR: result mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QUEUE_LIMIT) limit_reg = i_cfg_data[LIMIT_W-1:0];
                else capacity_reg = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                predicted = apply_request(t_req'(i_req_type), i_consumer_id,
                                          i_ack_buffer_id, i_needs_ack, i_data_size);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
    end

endmodule

@@ test/multi_consumer_ack_queue_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the multi-consumer acknowledgement queue: clock, reset, stimulus and verdict.
// Depends on mcaq_pkg, multi_consumer_ack_queue and mcaq_checker.
module multi_consumer_ack_queue_test;
    import mcaq_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [1:0]        i_req_type;
    logic [CID_W-1:0]  i_consumer_id;
    logic [BID_W-1:0]  i_ack_buffer_id;
    logic              i_needs_ack;
    logic [SIZE_W-1:0] i_data_size;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic              o_ok;
    logic [BID_W-1:0]  o_new_buffer_id;
    logic [SEQ_W-1:0]  o_new_sequence;
    logic [QCNT_W-1:0] o_queue_count;
    logic [RCNT_W-1:0] o_registered_count;
    logic [QCNT_W-1:0] o_fully_acked_count;

    int errors;
    int pending;
    int idle_pct;
    int publish_count;
    int requests_sent;
    int settings_used;
    logic [CID_W-1:0] id_pool[20];

    multi_consumer_ack_queue uut (.*);

    mcaq_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_req_type, .i_consumer_id,
        .i_ack_buffer_id, .i_needs_ack, .i_data_size, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(o_valid), .i_ok(o_ok), .i_new_buffer_id(o_new_buffer_id),
        .i_new_sequence(o_new_sequence), .i_queue_count(o_queue_count),
        .i_registered_count(o_registered_count), .i_fully_acked_count(o_fully_acked_count),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Sends one request beat and returns at the edge that accepts it, start still high.
    task automatic send(t_req req, logic [CID_W-1:0] cid, logic [BID_W-1:0] abid,
                        logic need, logic [SIZE_W-1:0] dsize);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_req_type      <= req;
        i_consumer_id   <= cid;
        i_ack_buffer_id <= abid;
        i_needs_ack     <= need;
        i_data_size     <= dsize;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        requests_sent++;
        if (req == REQ_PUBLISH) publish_count++;
    endtask

    // Lets the block drain, then writes one register while it is idle.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // One random request: mostly well-formed traffic over a small pool of consumers.
    task automatic random_request();
        int               pick;
        logic [CID_W-1:0] cid;
        logic [BID_W-1:0] abid;
        logic [SIZE_W-1:0] dsize;
        pick  = $urandom_range(99);
        cid   = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(19)];
        abid  = $urandom_range(publish_count + 1,
                               (publish_count > 12) ? publish_count - 12 : 1);
        if ($urandom_range(19) == 0) abid = {$urandom, $urandom};
        dsize = ($urandom_range(4) == 0) ? $urandom : $urandom_range(2000);
        if (pick < 20)      send(REQ_REGISTER, cid, abid, $urandom_range(1), dsize);
        else if (pick < 30) send(REQ_UNREGISTER, cid, abid, $urandom_range(1), dsize);
        else if (pick < 60) send(REQ_PUBLISH, cid, abid, $urandom_range(9) != 0, dsize);
        else                send(REQ_ACK, cid, abid, $urandom_range(1), dsize);
    endtask

    initial begin
        logic [LIMIT_W-1:0] limits[8];
        logic [CFG_W-1:0]   caps[8];
        limits = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd4, 4'd8};
        caps   = '{32'hFFFF_FFFF, 32'd1000, 32'd1500, 32'd0, 32'd65536,
                   32'd1800, 32'hFFFF_FFFF, 32'd2000};
        for (int i = 0; i < 20; i++) id_pool[i] = i * 32'h0D0B_0907;
        id_pool[19] = 32'hFFFF_FFFF;
        i_rst_n = 1'b0; i_start = 1'b0; i_req_type = '0; i_consumer_id = '0;
        i_ack_buffer_id = '0; i_needs_ack = 1'b0; i_data_size = '0;
        i_cfg_we = 1'b0; i_cfg_idx = 1'b0; i_cfg_data = '0;
        idle_pct = 12; publish_count = 0; requests_sent = 0; settings_used = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extreme IDs, duplicates, misses, oversize, purge and repeat acks.
        send(REQ_UNREGISTER, 32'd5, '0, 1'b0, '0);
        send(REQ_ACK, 32'd0, 64'd1, 1'b0, '0);
        send(REQ_REGISTER, 32'd0, '0, 1'b0, '0);
        send(REQ_REGISTER, 32'hFFFF_FFFF, '0, 1'b0, '0);
        send(REQ_REGISTER, 32'd0, '0, 1'b0, '0);
        send(REQ_PUBLISH, '0, '0, 1'b1, 32'hFFFF_FFFF);
        send(REQ_PUBLISH, '0, '0, 1'b1, 32'd65536);
        send(REQ_PUBLISH, '0, '0, 1'b0, 32'd0);
        send(REQ_PUBLISH, '0, '0, 1'b1, 32'd65537);
        send(REQ_ACK, 32'd0, 64'd1, 1'b0, '0);
        send(REQ_ACK, 32'hFFFF_FFFF, 64'd1, 1'b0, '0);
        send(REQ_ACK, 32'd0, 64'd1, 1'b0, '0);
        send(REQ_ACK, 32'd7, 64'd1, 1'b0, '0);
        send(REQ_ACK, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send(REQ_UNREGISTER, 32'hFFFF_FFFF, '0, 1'b0, '0);
        send(REQ_PUBLISH, '0, '0, 1'b1, 32'd10);
        for (int i = 1; i < 18; i++) send(REQ_REGISTER, id_pool[i], '0, 1'b0, '0);
        send(REQ_UNREGISTER, id_pool[3], '0, 1'b0, '0);

        // Random part in eight register settings and three idling phases.
        for (int n = 0; n < 800; n++) begin
            if (n % 100 == 0) begin
                write_reg(CFG_QUEUE_LIMIT, limits[n / 100]);
                write_reg(CFG_DATA_CAPACITY, caps[n / 100]);
            end
            idle_pct = (n < 270) ? 12 : (n < 540) ? 85 : 0;
            random_request();
        end
        i_start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Run covered %0d requests (%0d publishes) under %0d register writes,",
                 requests_sent, publish_count, settings_used);
        $display("with sender idling at 12, 85 and 0 percent.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mcaq_pkg.sv
hdl/mcaq_eq.sv
hdl/multi_consumer_ack_queue.sv
test/mcaq_checker.sv
test/multi_consumer_ack_queue_test.sv
